[src/mmbc_pkg.sv]
// Package for the multi-mode byte checksum: codes, types and CRC byte-update functions.
package mmbc_pkg;

    localparam int MODE_W      = 3;
    localparam int HOLE_W      = 27;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 27;
    localparam int SUM_W       = 32;

    localparam logic [31:0] CRC32_POLY_REFL = 32'hEDB8_8320;
    localparam logic [15:0] CRC16_POLY      = 16'h1021;
    localparam logic [31:0] CRC32_INIT      = 32'hFFFF_FFFF;
    localparam logic [15:0] CRC16_INIT      = 16'hFFFF;
    localparam logic [16:0] ADLER_MOD       = 17'd65521;

    // Checksum selection codes
    typedef enum logic [MODE_W-1:0] {
        MODE_CRC32  = 3'd0,
        MODE_CRC16  = 3'd1,
        MODE_ADLER  = 3'd2,
        MODE_SUM8   = 3'd3,
        MODE_SUM16  = 3'd4,
        MODE_SUM32  = 3'd5
    } mode_e;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE        = 2'd0,
        CFG_HOLE_START  = 2'd1,
        CFG_HOLE_LENGTH = 2'd2
    } cfg_index_e;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [HOLE_W-1:0] hole_start;
        logic [HOLE_W-1:0] hole_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // Reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] v);
        logic [31:0] r;
        r = c ^ {24'd0, v};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC32_POLY_REFL) : (r >> 1);
        end
        return r;
    endfunction

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] v);
        logic [15:0] r;
        r = c ^ {v, 8'd0};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ((r << 1) ^ CRC16_POLY) : (r << 1);
        end
        return r;
    endfunction

endpackage

[src/mmbc_if.sv]
// Stream interfaces for the byte input and the checksum output.
interface mmbc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mmbc_sum_if;
    logic        valid;
    logic        ready;
    logic [31:0] checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

[src/multi_mode_byte_checksum_top.sv]
// Multi-mode byte checksum: one byte per cycle; CRC-32 (with optional zeroed hole),
// CRC-16/CCITT-FALSE, Adler-32 or an 8/16/32-bit byte sum, emitted on the last byte.
// Throughput is one byte per clock unless a last byte is held; each byte passes an
// input register and the combinational accumulator update, and a checksum is loaded
// into the output register as its last byte leaves the input register. A last byte
// waits there, and holds off new bytes, while an earlier checksum is still unaccepted
// on the output. A new range starts on the byte right after a last byte. The user
// writes configuration (mode, hole start, hole length) through cfg_we/cfg_index/
// cfg_wdata only while no range is in flight; the block does not enforce this.
module multi_mode_byte_checksum_top
    import mmbc_pkg::*;
#(
    parameter longint unsigned MAX_RANGE_BYTES = 64'd67108864
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    mmbc_byte_if.sink              byte_in,
    mmbc_sum_if.source             sum_out
);

    cfg_t              cfg_reg;
    item_t             in_item_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  out_sum_reg;
    logic [SUM_W-1:0]  checksum_next;
    logic              out_free;
    logic              advance;

    // Handshake: process the held byte unless it must emit into a full output slot
    assign out_free      = !out_valid_reg || sum_out.ready;
    assign advance       = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign byte_in.ready = !in_valid_reg || advance;

    assign sum_out.valid    = out_valid_reg;
    assign sum_out.checksum = out_sum_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:        cfg_reg.mode        <= cfg_wdata[MODE_W-1:0];
                CFG_HOLE_START:  cfg_reg.hole_start  <= cfg_wdata[HOLE_W-1:0];
                CFG_HOLE_LENGTH: cfg_reg.hole_length <= cfg_wdata[HOLE_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            in_item_reg.data_byte <= byte_in.data_byte;
            in_item_reg.last_byte <= byte_in.last_byte;
        end
    end

    mmbc_engine #(
        .MAX_RANGE_BYTES (MAX_RANGE_BYTES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (in_item_reg),
        .cfg      (cfg_reg),
        .checksum (checksum_next)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_item_reg.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (sum_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_item_reg.last_byte)
        begin
            out_sum_reg <= checksum_next;
        end
    end

endmodule

[src/mmbc_engine.sv]
// Checksum accumulators: one byte update per step, result selected by mode.
module mmbc_engine
    import mmbc_pkg::*;
#(
    parameter longint unsigned MAX_RANGE_BYTES = 64'd67108864
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  item_t             item,
    input  cfg_t              cfg,
    output logic [SUM_W-1:0]  checksum
);

    localparam int OFS_W = $clog2(MAX_RANGE_BYTES + 64'd1);
    localparam int CMP_W = ((OFS_W > HOLE_W) ? OFS_W : HOLE_W) + 1;
    localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MAX_RANGE_BYTES);

    logic [31:0]      crc32_reg, crc32_next;
    logic [15:0]      crc16_reg, crc16_next;
    logic [15:0]      adler_low_reg, adler_low_next;
    logic [15:0]      adler_high_reg, adler_high_next;
    logic [31:0]      byte_total_reg, byte_total_next;
    logic [OFS_W-1:0] byte_offset_reg, byte_offset_next;

    logic [CMP_W-1:0] ofs_ext, start_ext, len_ext, rel;
    logic             in_hole;
    logic [7:0]       crc_in;
    logic [16:0]      low_sum, high_sum;

    // Hole test on the current offset; end computed without wrap
    always_comb
    begin
        ofs_ext   = CMP_W'(byte_offset_reg);
        start_ext = CMP_W'(cfg.hole_start);
        len_ext   = CMP_W'(cfg.hole_length);
        rel       = ofs_ext - start_ext;
        in_hole   = (cfg.hole_length != '0) && (ofs_ext >= start_ext) && (rel < len_ext);
        crc_in    = in_hole ? 8'd0 : item.data_byte;
    end

    // Next accumulator values
    always_comb
    begin
        crc32_next      = crc32_byte(crc32_reg, crc_in);
        crc16_next      = crc16_byte(crc16_reg, item.data_byte);
        low_sum         = {1'b0, adler_low_reg} + {9'd0, item.data_byte};
        if (low_sum >= ADLER_MOD)
        begin
            low_sum = low_sum - ADLER_MOD;
        end
        adler_low_next  = low_sum[15:0];
        high_sum        = {1'b0, adler_high_reg} + {1'b0, adler_low_next};
        if (high_sum >= ADLER_MOD)
        begin
            high_sum = high_sum - ADLER_MOD;
        end
        adler_high_next = high_sum[15:0];
        byte_total_next = byte_total_reg + {24'd0, item.data_byte};
        byte_offset_next = (byte_offset_reg < OFS_MAX) ? byte_offset_reg + OFS_W'(1)
                                                       : byte_offset_reg;
    end

    // Result select from the updated accumulators
    always_comb
    begin
        case (cfg.mode)
            MODE_CRC32: checksum = ~crc32_next;
            MODE_CRC16: checksum = {16'd0, crc16_next};
            MODE_ADLER: checksum = {adler_high_next, adler_low_next};
            MODE_SUM8:  checksum = {24'd0, byte_total_next[7:0]};
            MODE_SUM16: checksum = {16'd0, byte_total_next[15:0]};
            MODE_SUM32: checksum = byte_total_next;
            default:    checksum = '0;
        endcase
    end

    // Accumulator state; re-init after the last byte of a range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc32_reg       <= CRC32_INIT;
            crc16_reg       <= CRC16_INIT;
            adler_low_reg   <= 16'd1;
            adler_high_reg  <= 16'd0;
            byte_total_reg  <= '0;
            byte_offset_reg <= '0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                crc32_reg       <= CRC32_INIT;
                crc16_reg       <= CRC16_INIT;
                adler_low_reg   <= 16'd1;
                adler_high_reg  <= 16'd0;
                byte_total_reg  <= '0;
                byte_offset_reg <= '0;
            end
            else
            begin
                crc32_reg       <= crc32_next;
                crc16_reg       <= crc16_next;
                adler_low_reg   <= adler_low_next;
                adler_high_reg  <= adler_high_next;
                byte_total_reg  <= byte_total_next;
                byte_offset_reg <= byte_offset_next;
            end
        end
    end

endmodule

[tb/multi_mode_byte_checksum_top_tb.sv]
// Self-checking testbench for the multi-mode byte checksum block.
`timescale 1ns / 100ps

module multi_mode_byte_checksum_top_tb;
    import mmbc_pkg::*;

    localparam longint unsigned RANGE_LIMIT    = 64'd67108864;
    localparam int              RESULT_LATENCY = 2;
    localparam int              RANDOM_BYTES   = 1880;
    localparam int              QUIET_BYTES    = 300;
    localparam int              LIMIT_NS       = 3_000_000;
    localparam int              N_DIRECTED     = 34;
    localparam int              REPORT_MAX     = 10;

    // Mode codes with no checksum behind them
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

    localparam logic [CFG_DATA_W-1:0] HOLE_ALL_ONES = 27'h7FF_FFFF;
    localparam logic [CFG_DATA_W-1:0] HOLE_MAX_SPAN = 27'h400_0000;

    typedef enum logic {
        ROW_CFG,
        ROW_BYTE
    } row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        cfg_index_e             reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic [7:0]             data_byte;
        logic                   last_byte;
        logic                   has_sum;
        logic [31:0]            sum;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    mmbc_byte_if byte_ch ();
    mmbc_sum_if  sum_ch ();

    multi_mode_byte_checksum_top #(
        .MAX_RANGE_BYTES (RANGE_LIMIT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .byte_in   (byte_ch),
        .sum_out   (sum_ch)
    );

    // Shadow of the configuration registers
    logic [MODE_W-1:0]     mode_sh;
    logic [HOLE_W-1:0]     hole_start_sh;
    logic [HOLE_W-1:0]     hole_len_sh;

    // Running accumulators of the open range
    logic [31:0]           crc32_acc;
    logic [15:0]           crc16_acc;
    logic [15:0]           adler_lo;
    logic [15:0]           adler_hi;
    logic [31:0]           byte_sum;
    longint unsigned       range_pos;

    logic [31:0]           pending_sums[$];
    int                    idle_pct;
    int                    error_count;
    int                    sums_checked;
    int                    bytes_sent;
    int                    settings_used;

    // Directed stimulus; sums are typed in only where obvious
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'h00, 1'b1, 1'b1, 32'hD202_EF8D},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'hFF, 1'b1, 1'b1, 32'hFF00_0000},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'h12, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'h34, 1'b1, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_HOLE_START,  27'd1, 8'h00, 1'b0, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_HOLE_LENGTH, 27'd1, 8'h00, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'hAB, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'hCD, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'hEF, 1'b1, 1'b0, 32'd0},
        // hole running far past the end of the range
        '{ROW_CFG,  CFG_HOLE_START,  27'd2, 8'h00, 1'b0, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_HOLE_LENGTH, HOLE_ALL_ONES, 8'h00, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'h01, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'h02, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'h03, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'h04, 1'b1, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_MODE, CFG_DATA_W'(MODE_CRC16), 8'h00, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'h00, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'hFF, 1'b1, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_MODE, CFG_DATA_W'(MODE_ADLER), 8'h00, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'hFF, 1'b1, 1'b1, 32'h0100_0100},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'h00, 1'b1, 1'b1, 32'h0001_0001},
        '{ROW_CFG,  CFG_MODE, CFG_DATA_W'(MODE_SUM8), 8'h00, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'hFF, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'hFF, 1'b1, 1'b1, 32'h0000_00FE},
        '{ROW_CFG,  CFG_MODE, CFG_DATA_W'(MODE_SUM16), 8'h00, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'hFF, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'hFF, 1'b1, 1'b1, 32'h0000_01FE},
        '{ROW_CFG,  CFG_MODE, CFG_DATA_W'(MODE_SUM32), 8'h00, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'hFF, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'hFF, 1'b1, 1'b1, 32'h0000_01FE},
        // unused mode codes give a zero checksum
        '{ROW_CFG,  CFG_MODE, CFG_DATA_W'(MODE_SPARE6), 8'h00, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'hA5, 1'b1, 1'b1, 32'd0},
        '{ROW_CFG,  CFG_MODE, CFG_DATA_W'(MODE_SPARE7), 8'h00, 1'b0, 1'b0, 32'd0},
        '{ROW_BYTE, CFG_MODE, 27'd0, 8'h5A, 1'b1, 1'b1, 32'd0}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on run time
    initial
    begin
        #(LIMIT_NS);
        $display("Timeout with %0d checksums still outstanding", pending_sums.size());
        $display("Regression FAIL");
        $finish;
    end

    // Return all accumulators to their start-of-range values
    function automatic void restart_range();
        crc32_acc = CRC32_INIT;
        crc16_acc = CRC16_INIT;
        adler_lo  = 16'd1;
        adler_hi  = 16'd0;
        byte_sum  = 32'd0;
        range_pos = 64'd0;
    endfunction

    // Fold one byte into every accumulator; returns 1 with the checksum on a last byte
    function automatic bit fold_byte(input logic [7:0] b, input logic l,
                                     output logic [31:0] sum);
        logic [7:0]  crc_in;
        logic [16:0] lo;
        logic [16:0] hi;
        longint unsigned hs;

        hs = longint'(hole_start_sh);
        crc_in = b;
        if (hole_len_sh != 0 && range_pos >= hs && (range_pos - hs) < hole_len_sh)
            crc_in = 8'h00;

        // reflected CRC-32, one bit at a time
        crc32_acc ^= {24'd0, crc_in};
        for (int k = 0; k < 8; k++)
            crc32_acc = (crc32_acc >> 1) ^ (CRC32_POLY_REFL & {32{crc32_acc[0]}});

        // CRC-16 CCITT, MSB first
        crc16_acc ^= {b, 8'h00};
        for (int k = 0; k < 8; k++)
            crc16_acc = (crc16_acc << 1) ^ (CRC16_POLY & {16{crc16_acc[15]}});

        // Adler-32 with a single conditional subtract per sum
        lo = {1'b0, adler_lo} + {9'd0, b};
        if (lo >= ADLER_MOD)
            lo -= ADLER_MOD;
        hi = {1'b0, adler_hi} + lo;
        if (hi >= ADLER_MOD)
            hi -= ADLER_MOD;
        adler_lo = lo[15:0];
        adler_hi = hi[15:0];

        byte_sum += {24'd0, b};
        if (range_pos < RANGE_LIMIT)
            range_pos++;

        sum = 32'd0;
        if (!l)
            return 1'b0;

        case (mode_sh)
            MODE_CRC32: sum = ~crc32_acc;
            MODE_CRC16: sum = {16'd0, crc16_acc};
            MODE_ADLER: sum = {adler_hi, adler_lo};
            MODE_SUM8:  sum = {24'd0, byte_sum[7:0]};
            MODE_SUM16: sum = {16'd0, byte_sum[15:0]};
            MODE_SUM32: sum = byte_sum;
            default:    sum = 32'd0;
        endcase
        restart_range();
        return 1'b1;
    endfunction

    function automatic void log_failure(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("%t: %s: expected %08h, got %08h", $realtime, what, want, got);
    endfunction

    // Register write, issued only once every pending checksum has come out
    task automatic write_reg(input cfg_index_e idx, input logic [CFG_DATA_W-1:0] value);
        byte_ch.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_MODE:        mode_sh       = value[MODE_W-1:0];
            CFG_HOLE_START:  hole_start_sh = value[HOLE_W-1:0];
            CFG_HOLE_LENGTH: hole_len_sh   = value[HOLE_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one byte, wait for the transaction, then predict its outcome
    task automatic push_byte(input logic [7:0] b, input logic l,
                             input logic typed, input logic [31:0] typed_sum);
        logic [31:0] sum;

        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= l;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
        if (fold_byte(b, l, sum))
            pending_sums.push_back(typed ? typed_sum : sum);
    endtask

    // Checksum sink: compare each transaction, stall in random bursts
    initial
    begin
        int          stall_left;
        logic [31:0] want;

        stall_left = 0;
        sum_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && sum_ch.valid && sum_ch.ready)
            begin
                if (pending_sums.size() == 0)
                begin
                    log_failure("unexpected checksum", 32'd0, sum_ch.checksum);
                end
                else
                begin
                    want = pending_sums.pop_front();
                    if (sum_ch.checksum !== want)
                        log_failure("checksum mismatch", want, sum_ch.checksum);
                    sums_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                sum_ch.ready <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                sum_ch.ready <= 1'b0;
            end
            else
            begin
                sum_ch.ready <= 1'b1;
            end
        end
    end

    // Main sequence
    initial
    begin
        int          range_len;
        int          range_count;
        int          fill_kind;
        logic [7:0]  b;
        logic [CFG_DATA_W-1:0] value;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_MODE;
        cfg_wdata         <= '0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        byte_ch.last_byte <= 1'b0;
        error_count   = 0;
        sums_checked  = 0;
        bytes_sent    = 0;
        settings_used = 1;
        idle_pct      = 25;
        mode_sh       = MODE_CRC32;
        hole_start_sh = '0;
        hole_len_sh   = '0;
        restart_range();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
                settings_used++;
            end
            else
            begin
                push_byte(directed_rows[i].data_byte, directed_rows[i].last_byte,
                          directed_rows[i].has_sum, directed_rows[i].sum);
            end
        end

        // Random phases: new setting, then a handful of complete ranges
        while (bytes_sent < RANDOM_BYTES)
        begin
            value = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'(MODE_CRC32)
                                                : CFG_DATA_W'($urandom_range(0, 7));
            write_reg(CFG_MODE, value);
            case ($urandom_range(0, 4))
                0:       value = '0;
                1, 2:    value = CFG_DATA_W'($urandom_range(0, 24));
                3:       value = HOLE_ALL_ONES;
                default: value = CFG_DATA_W'($urandom());
            endcase
            write_reg(CFG_HOLE_START, value);
            case ($urandom_range(0, 5))
                0:       value = '0;
                1, 2:    value = CFG_DATA_W'($urandom_range(1, 24));
                3:       value = HOLE_ALL_ONES;
                4:       value = HOLE_MAX_SPAN;
                default: value = CFG_DATA_W'($urandom());
            endcase
            write_reg(CFG_HOLE_LENGTH, value);
            settings_used++;

            // idling level for this phase; the tail of the run has none
            if (bytes_sent >= RANDOM_BYTES - QUIET_BYTES)
            begin
                idle_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    2:       idle_pct = 25;
                    default: idle_pct = 50;
                endcase
            end

            range_count = $urandom_range(2, 10);
            repeat (range_count)
            begin
                case ($urandom_range(0, 9))
                    0:       range_len = 1;
                    8:       range_len = $urandom_range(13, 40);
                    9:       range_len = $urandom_range(41, 96);
                    default: range_len = $urandom_range(2, 12);
                endcase
                fill_kind = $urandom_range(0, 9);
                for (int k = 0; k < range_len; k++)
                begin
                    case (fill_kind)
                        0:       b = 8'hFF;
                        1:       b = 8'h00;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    push_byte(b, k == range_len - 1, 1'b0, 32'd0);
                end
            end
        end

        // Drain
        byte_ch.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 8) @(posedge clk);

        $display("Sent %0d bytes under %0d register settings, %0d checksums compared",
                 bytes_sent, settings_used, sums_checked);
        $display("Failures: %0d", error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
